### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the clipper blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, off in reset
`define AST_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never be true
`define AST_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

### hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants shared by the triangle plane clipper modules.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int DIST_W      = 52;  // signed plane distance width
  localparam int COORD_W     = 32;
  localparam int COLOR_W     = 24;
  localparam int QDEPTH_DEF  = 4;

  // register indexes
  localparam logic [1:0] REG_NX = 2'd0;
  localparam logic [1:0] REG_NY = 2'd1;
  localparam logic [1:0] REG_NZ = 2'd2;
  localparam logic [1:0] REG_W  = 2'd3;

  typedef logic [2:0][COORD_W-1:0] vec_t;  // [0]=x [1]=y [2]=z

  typedef struct packed {
    logic signed [31:0] vert_a_x;
    logic signed [31:0] vert_a_y;
    logic signed [31:0] vert_a_z;
    logic signed [31:0] vert_b_x;
    logic signed [31:0] vert_b_y;
    logic signed [31:0] vert_b_z;
    logic signed [31:0] vert_c_x;
    logic signed [31:0] vert_c_y;
    logic signed [31:0] vert_c_z;
    logic [23:0]        tri_color;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_a_x;
    logic signed [31:0] out_a_y;
    logic signed [31:0] out_a_z;
    logic signed [31:0] out_b_x;
    logic signed [31:0] out_b_y;
    logic signed [31:0] out_b_z;
    logic signed [31:0] out_c_x;
    logic signed [31:0] out_c_y;
    logic signed [31:0] out_c_z;
    logic [23:0]        out_color;
    logic               keeps_texture;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] w;
  } plane_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  // classified triangle: A, B, C already in emit order
  typedef struct packed {
    kind_t                    kind;
    vec_t                     va;
    vec_t                     vb;
    vec_t                     vc;
    logic signed [DIST_W-1:0] da;
    logic signed [DIST_W-1:0] db;
    logic signed [DIST_W-1:0] dc;
    logic [COLOR_W-1:0]       color;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic no_room;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_NORM,
    B_DIV,
    B_MULT,
    B_ACC,
    B_EMIT0,
    B_EMIT1
  } back_state_t;

endpackage

### hdl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// Plane distance of each vertex and inside/outside classification.
// ----------------------------------------------------------------------------
module tpc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  tpc_pkg::in_item_t  in_item,
  input  tpc_pkg::plane_t    plane,
  output logic            s1_valid,
  output logic            push,
  output tpc_pkg::entry_t    entry
);
  import tpc_pkg::*;

  logic                      s1_valid_r;
  logic signed [2:0][2:0][63:0] prod_r;
  vec_t                      v_r [3];
  logic [COLOR_W-1:0]        color_r;
  vec_t                      vin [3];
  logic signed [DIST_W-1:0]  d [3];
  logic [2:0]                ins;

  assign vin[0] = {in_item.vert_a_z, in_item.vert_a_y, in_item.vert_a_x};
  assign vin[1] = {in_item.vert_b_z, in_item.vert_b_y, in_item.vert_b_x};
  assign vin[2] = {in_item.vert_c_z, in_item.vert_c_y, in_item.vert_c_x};

  // stage 1: exact products of normal and coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= plane.nx * $signed(vin[i][0]);
        prod_r[i][1] <= plane.ny * $signed(vin[i][1]);
        prod_r[i][2] <= plane.nz * $signed(vin[i][2]);
        v_r[i]       <= vin[i];
      end
      color_r <= in_item.tri_color;
    end
  end

  // stage 2: floored terms plus offset, inside test
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = DIST_W'($signed(prod_r[i][0][63:16])) +
             DIST_W'($signed(prod_r[i][1][63:16])) +
             DIST_W'($signed(prod_r[i][2][63:16])) +
             DIST_W'(plane.w);
      ins[i] = (d[i] > 0);
    end
  end

  // order vertices so that A, B, C follow the emit pattern
  always_comb begin
    entry.color = color_r;
    entry.kind  = KIND_PASS;
    entry.va = v_r[0]; entry.vb = v_r[1]; entry.vc = v_r[2];
    entry.da = d[0];   entry.db = d[1];   entry.dc = d[2];
    unique case (ins)
      3'b001: begin
        entry.kind = KIND_ONE;
      end
      3'b010: begin
        entry.kind = KIND_ONE;
        entry.va = v_r[1]; entry.vb = v_r[0];
        entry.da = d[1];   entry.db = d[0];
      end
      3'b100: begin
        entry.kind = KIND_ONE;
        entry.va = v_r[2]; entry.vb = v_r[0]; entry.vc = v_r[1];
        entry.da = d[2];   entry.db = d[0];   entry.dc = d[1];
      end
      3'b011: begin
        entry.kind = KIND_TWO;
      end
      3'b101: begin
        entry.kind = KIND_TWO;
        entry.vb = v_r[2]; entry.vc = v_r[1];
        entry.db = d[2];   entry.dc = d[1];
      end
      3'b110: begin
        entry.kind = KIND_TWO;
        entry.va = v_r[1]; entry.vb = v_r[2]; entry.vc = v_r[0];
        entry.da = d[1];   entry.db = d[2];   entry.dc = d[0];
      end
      default: begin
        entry.kind = KIND_PASS;
      end
    endcase
  end

  // drop fully outside triangles here
  assign push     = s1_valid_r && (ins != 3'b000);
  assign s1_valid = s1_valid_r;

endmodule

### hdl/tpc_fifo.sv
// ----------------------------------------------------------------------------
// tpc_fifo
// Short queue of classified triangles between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpc_fifo #(
  parameter int DEPTH = tpc_pkg::QDEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tpc_pkg::entry_t     wr_entry,
  input  logic                pop,
  input  logic                reserve,
  output tpc_pkg::entry_t     head,
  output tpc_pkg::fifo_stat_t stat
);
  import tpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign stat.empty    = (count_r == '0);
  // count a triangle still in the front as taken room
  assign stat.no_room  = ({1'b0, count_r} + (CNT_W+1)'(reserve)) >= (CNT_W+1)'(DEPTH);

  `AST_NEVER(a_no_overflow, clk, rst_n, push && !pop && (count_r == CNT_W'(DEPTH)))
  `AST_NEVER(a_no_underflow, clk, rst_n, pop && (count_r == '0))

endmodule

### hdl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// Intersection sequencer and result emit for classified triangles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tpc_pkg::fifo_stat_t stat,
  input  tpc_pkg::entry_t     head,
  output logic                pop,
  output logic                out_valid,
  output tpc_pkg::out_item_t  out_item
);
  import tpc_pkg::*;

  back_state_t              state_r, state_nxt;
  entry_t                   e_r;
  logic                     job_r;
  logic [1:0]               crd_r;
  logic [4:0]               cnt_r;
  logic [DIST_W-1:0]        den_r;
  logic [DIST_W-1:0]        num_r;
  logic [31:0]              q_r;
  logic [31:0]              rem_r;
  logic signed [65:0]       prod_r;
  vec_t                     m_r [2];
  logic                     out_valid_r;
  out_item_t                out_r;

  logic                     one;
  vec_t                     pv, qv;
  logic signed [DIST_W-1:0] pd, qd;
  logic                     norm_done;
  logic [31:0]              rem_sh;
  logic                     div_ge;
  logic                     init_ge;
  logic signed [32:0]       diff;
  logic signed [65:0]       rnd;
  logic [31:0]              res;

  function automatic out_item_t mk_tri(vec_t a, vec_t b, vec_t c,
                                       logic [COLOR_W-1:0] col,
                                       logic keep, logic last);
    out_item_t o;
    o.out_a_x = a[0]; o.out_a_y = a[1]; o.out_a_z = a[2];
    o.out_b_x = b[0]; o.out_b_y = b[1]; o.out_b_z = b[2];
    o.out_c_x = c[0]; o.out_c_y = c[1]; o.out_c_z = c[2];
    o.out_color     = col;
    o.keeps_texture = keep;
    o.last_of_run   = last;
    return o;
  endfunction

  // select endpoints of the current intersection
  always_comb begin
    one = (e_r.kind == KIND_ONE);
    if (!job_r) begin
      pv = e_r.va;               pd = e_r.da;
      qv = one ? e_r.vb : e_r.vc; qd = one ? e_r.db : e_r.dc;
    end else begin
      pv = one ? e_r.va : e_r.vb; pd = one ? e_r.da : e_r.db;
      qv = e_r.vc;               qd = e_r.dc;
    end
  end

  // datapath helpers
  assign norm_done = (den_r[DIST_W-1:31] == '0);
  assign init_ge   = (num_r[31:0] >= den_r[31:0]);
  assign rem_sh    = {rem_r[30:0], 1'b0};
  assign div_ge    = (rem_sh >= den_r[31:0]);
  assign diff      = {pv[crd_r][31], pv[crd_r]} - {qv[crd_r][31], qv[crd_r]};
  assign rnd       = prod_r + 66'sd1073741824;
  assign res       = pv[crd_r] + 32'(rnd >>> 31);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!stat.empty) state_nxt = (head.kind == KIND_PASS) ? B_EMIT0 : B_SETUP;
      end
      B_SETUP: state_nxt = B_NORM;
      B_NORM:  if (norm_done) state_nxt = B_DIV;
      B_DIV:   if (cnt_r == 5'd30) state_nxt = B_MULT;
      B_MULT:  state_nxt = B_ACC;
      B_ACC: begin
        if (crd_r != 2'd2) state_nxt = B_MULT;
        else if (!job_r)   state_nxt = B_SETUP;
        else               state_nxt = B_EMIT0;
      end
      B_EMIT0: state_nxt = (e_r.kind == KIND_TWO) ? B_EMIT1 : B_IDLE;
      B_EMIT1: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop = 1'b0;
    unique case (state_r)
      B_IDLE:  pop = !stat.empty;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == B_EMIT0) || (state_r == B_EMIT1);
    end
  end

  // datapath: load, normalize, divide, interpolate, emit
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        e_r   <= head;
        job_r <= 1'b0;
      end
      B_SETUP: begin
        den_r <= DIST_W'(pd - qd);
        num_r <= DIST_W'(pd);
      end
      B_NORM: begin
        if (!norm_done) begin
          den_r <= den_r >> 1;
          num_r <= num_r >> 1;
        end else begin
          q_r   <= {31'd0, init_ge};
          rem_r <= init_ge ? num_r[31:0] - den_r[31:0] : num_r[31:0];
          cnt_r <= '0;
          crd_r <= '0;
        end
      end
      B_DIV: begin
        q_r   <= {q_r[30:0], div_ge};
        rem_r <= div_ge ? rem_sh - den_r[31:0] : rem_sh;
        cnt_r <= cnt_r + 1'b1;
      end
      B_MULT: begin
        prod_r <= -(diff * $signed({1'b0, q_r}));
      end
      B_ACC: begin
        m_r[job_r][crd_r] <= res;
        crd_r <= crd_r + 1'b1;
        if (crd_r == 2'd2) job_r <= 1'b1;
      end
      B_EMIT0: begin
        if (e_r.kind == KIND_PASS) begin
          out_r <= mk_tri(e_r.va, e_r.vb, e_r.vc, e_r.color, 1'b1, 1'b1);
        end else begin
          out_r <= mk_tri(e_r.va, m_r[0], m_r[1], e_r.color, 1'b0,
                          e_r.kind != KIND_TWO);
        end
      end
      B_EMIT1: begin
        out_r <= mk_tri(e_r.va, m_r[1], e_r.vb, e_r.color, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `AST_PROP(a_pair, clk, rst_n, out_valid_r && !out_r.last_of_run |=> out_valid_r)
  `AST_PROP(a_div_norm, clk, rst_n, (state_r == B_DIV) |-> norm_done)
  `AST_PROP(a_pop_load, clk, rst_n, pop |=> (state_r == B_SETUP || state_r == B_EMIT0))

endmodule

### hdl/triangle_plane_clipper_core.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// Clips one triangle against a configured plane, up to two results each.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         start / busy            in_data   (in_item_t)
// result    out        out_valid strobe        out_data  (out_item_t)
// config    in/out     psel/penable/pready     paddr, pwdata, prdata
//
// The front takes a triangle each cycle while busy is low, registers the
// products, then classifies it into the queue; a fully outside triangle
// stops there. The back sequencer sets the rate: a pass-through triangle
// goes straight to emit; a clipped one runs setup, normalize, bit-serial
// divide and three multiply-accumulate steps per intersection, then one
// emit, or two for two results. A result strobes the cycle after its emit
// state. busy rises while the queue holds no room; results cannot be held
// off. Reset is synchronous, active low, and loads the default plane z = 1.
// ----------------------------------------------------------------------------
module triangle_plane_clipper_core #(
  parameter int QUEUE_DEPTH = tpc_pkg::QDEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tpc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output tpc_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tpc_pkg::*;

  plane_t     plane_r;
  logic       accept;
  logic       wr_en;
  logic       s1_valid;
  logic       push;
  logic       pop;
  entry_t     entry;
  entry_t     head;
  fifo_stat_t stat;

  // register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.nx <= 32'sd0;
      plane_r.ny <= 32'sd0;
      plane_r.nz <= 32'sd65536;
      plane_r.w  <= -32'sd65536;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_NX:  plane_r.nx <= pwdata;
        REG_NY:  plane_r.ny <= pwdata;
        REG_NZ:  plane_r.nz <= pwdata;
        REG_W:   plane_r.w  <= pwdata;
        default: plane_r    <= plane_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_NX:  prdata = plane_r.nx;
      REG_NY:  prdata = plane_r.ny;
      REG_NZ:  prdata = plane_r.nz;
      REG_W:   prdata = plane_r.w;
      default: prdata = '0;
    endcase
  end

  assign busy   = stat.no_room;
  assign accept = start && !busy;

  tpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .plane    (plane_r),
    .s1_valid (s1_valid),
    .push     (push),
    .entry    (entry)
  );

  tpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .reserve  (s1_valid),
    .head     (head),
    .stat     (stat)
  );

  tpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

### tb/tpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpc_checker
// Watches the triangle, result and register ports of the plane clipper,
// predicts the clipped triangles of every accepted transaction and compares
// them field by field, in order, with the strobed results.
// ----------------------------------------------------------------------------
module tpc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  tpc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  tpc_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending,
  output int                 n_results,
  output int                 n_clipped
);
  import tpc_pkg::*;

  out_item_t  tri_expected[$];
  logic [31:0] plane_nx, plane_ny, plane_nz, plane_w;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // signed distance of one vertex to the plane, each product floored to Q16.16
  function automatic longint plane_distance(input longint p[3]);
    longint acc;
    acc = ((longint'(signed'(plane_nx)) * p[0]) >>> 16) +
          ((longint'(signed'(plane_ny)) * p[1]) >>> 16) +
          ((longint'(signed'(plane_nz)) * p[2]) >>> 16) +
          longint'(signed'(plane_w));
    return acc;
  endfunction

  // edge/plane crossing from inside vertex p toward outside vertex q
  function automatic void edge_cross(input longint p[3], input longint dp,
                                     input longint q[3], input longint dq,
                                     output logic [31:0] r[3]);
    longint den, num, frac, prod;
    den = dp - dq;
    num = dp;
    while (den >= (longint'(1) << 31)) begin
      den = den >>> 1;
      num = num >>> 1;
    end
    frac = (num << 31) / den;
    for (int i = 0; i < 3; i++) begin
      prod = (q[i] - p[i]) * frac;
      r[i] = 32'(p[i] + ((prod + (longint'(1) << 30)) >>> 31));
    end
  endfunction

  function automatic out_item_t make_tri(input logic [31:0] a[3],
                                         input logic [31:0] b[3],
                                         input logic [31:0] c[3],
                                         input logic [23:0] color,
                                         input logic keep);
    out_item_t o;
    o.out_a_x = a[0]; o.out_a_y = a[1]; o.out_a_z = a[2];
    o.out_b_x = b[0]; o.out_b_y = b[1]; o.out_b_z = b[2];
    o.out_c_x = c[0]; o.out_c_y = c[1]; o.out_c_z = c[2];
    o.out_color = color;
    o.keeps_texture = keep;
    o.last_of_run = 1'b0;
    return o;
  endfunction

  // classify the triangle and queue the triangles it should produce
  task automatic predict_clip(input in_item_t t);
    longint v[3][3];
    longint d[3];
    logic [31:0] w[3][3];
    logic [31:0] m0[3], m1[3];
    int ins[3], outs[3];
    int n_in, n_out, first;
    out_item_t o0, o1;
    n_in = 0;
    n_out = 0;
    v[0] = '{t.vert_a_x, t.vert_a_y, t.vert_a_z};
    v[1] = '{t.vert_b_x, t.vert_b_y, t.vert_b_z};
    v[2] = '{t.vert_c_x, t.vert_c_y, t.vert_c_z};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) w[i][j] = 32'(v[i][j]);
      d[i] = plane_distance(v[i]);
      if (d[i] > 0) begin
        ins[n_in] = i;
        n_in++;
      end else begin
        outs[n_out] = i;
        n_out++;
      end
    end
    first = tri_expected.size();
    case (n_in)
      3: tri_expected.push_back(make_tri(w[0], w[1], w[2], t.tri_color, 1'b1));
      1: begin
        edge_cross(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], m0);
        edge_cross(v[ins[0]], d[ins[0]], v[outs[1]], d[outs[1]], m1);
        tri_expected.push_back(make_tri(w[ins[0]], m0, m1, t.tri_color, 1'b0));
      end
      2: begin
        edge_cross(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], m0);
        edge_cross(v[ins[1]], d[ins[1]], v[outs[0]], d[outs[0]], m1);
        o0 = make_tri(w[ins[0]], m0, m1, t.tri_color, 1'b0);
        o1 = make_tri(w[ins[0]], m1, w[ins[1]], t.tri_color, 1'b0);
        tri_expected.push_back(o0);
        tri_expected.push_back(o1);
      end
      default: ;
    endcase
    // flag the final triangle of this transaction
    if (tri_expected.size() > first)
      tri_expected[tri_expected.size()-1].last_of_run = 1'b1;
  endtask

  task automatic compare_tri(input out_item_t got, input out_item_t exp_t);
    if (got.out_a_x !== exp_t.out_a_x) report($sformatf("a_x %h exp %h", got.out_a_x, exp_t.out_a_x));
    if (got.out_a_y !== exp_t.out_a_y) report($sformatf("a_y %h exp %h", got.out_a_y, exp_t.out_a_y));
    if (got.out_a_z !== exp_t.out_a_z) report($sformatf("a_z %h exp %h", got.out_a_z, exp_t.out_a_z));
    if (got.out_b_x !== exp_t.out_b_x) report($sformatf("b_x %h exp %h", got.out_b_x, exp_t.out_b_x));
    if (got.out_b_y !== exp_t.out_b_y) report($sformatf("b_y %h exp %h", got.out_b_y, exp_t.out_b_y));
    if (got.out_b_z !== exp_t.out_b_z) report($sformatf("b_z %h exp %h", got.out_b_z, exp_t.out_b_z));
    if (got.out_c_x !== exp_t.out_c_x) report($sformatf("c_x %h exp %h", got.out_c_x, exp_t.out_c_x));
    if (got.out_c_y !== exp_t.out_c_y) report($sformatf("c_y %h exp %h", got.out_c_y, exp_t.out_c_y));
    if (got.out_c_z !== exp_t.out_c_z) report($sformatf("c_z %h exp %h", got.out_c_z, exp_t.out_c_z));
    if (got.out_color !== exp_t.out_color)
      report($sformatf("color %h exp %h", got.out_color, exp_t.out_color));
    if (got.keeps_texture !== exp_t.keeps_texture)
      report($sformatf("keeps_texture %b exp %b", got.keeps_texture, exp_t.keeps_texture));
    if (got.last_of_run !== exp_t.last_of_run)
      report($sformatf("last_of_run %b exp %b", got.last_of_run, exp_t.last_of_run));
  endtask

  initial begin
    errors = 0;
    pending = 0;
    n_results = 0;
    n_clipped = 0;
  end

  always @(posedge clk) begin
    out_item_t exp_t;
    if (!rst_n) begin
      plane_nx <= 32'd0;
      plane_ny <= 32'd0;
      plane_nz <= 32'h0001_0000;
      plane_w  <= 32'hFFFF_0000;
      tri_expected.delete();
    end else begin
      // check a strobed result against the oldest expectation
      if (out_valid === 1'b1) begin
        n_results++;
        if (tri_expected.size() == 0) begin
          report("result with nothing expected");
        end else begin
          exp_t = tri_expected.pop_front();
          if (!exp_t.keeps_texture) n_clipped++;
          compare_tri(out_data, exp_t);
        end
      end
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NX: plane_nx <= pwdata;
          REG_NY: plane_ny <= pwdata;
          REG_NZ: plane_nz <= pwdata;
          REG_W:  plane_w  <= pwdata;
          default: ;
        endcase
      end
      // predict an accepted triangle transaction
      if (start && !busy) predict_clip(in_data);
    end
    pending = tri_expected.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives triangles and plane settings into the clipper with random gaps and
// lets the checker judge every result triangle that comes back.
// ----------------------------------------------------------------------------
module tb_top;
  import tpc_pkg::*;

  localparam int ITEMS_PER_PLANE = 265;
  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam int DRAIN_CYCLES    = 200;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending, n_results, n_clipped;
  int          n_sent;
  int          cycles;
  bit          no_gaps;

  triangle_plane_clipper_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  tpc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .n_results(n_results),
    .n_clipped(n_clipped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stop a hung run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // let the block drain, including triangles that produce nothing
  task automatic settle();
    @(posedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_plane(input logic [31:0] nx, input logic [31:0] ny,
                           input logic [31:0] nz, input logic [31:0] w);
    settle();
    write_reg(REG_NX, nx);
    write_reg(REG_NY, ny);
    write_reg(REG_NZ, nz);
    write_reg(REG_W, w);
  endtask

  // hold start until the transaction is taken
  task automatic send_tri(input in_item_t t);
    while (!no_gaps && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= t;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    n_sent++;
  endtask

  function automatic in_item_t tri_of(input int ax, ay, az, bx, by, bz,
                                      input int cx, cy, cz, input int color);
    in_item_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz, color[23:0]};
    return t;
  endfunction

  // mostly coordinates near the plane, sometimes anything at all
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic in_item_t rand_tri();
    in_item_t t;
    t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord(), 24'($urandom)};
    return t;
  endfunction

  task automatic random_run(input int count);
    repeat (count) send_tri(rand_tri());
  endtask

  localparam int ONE = 65536;

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    n_sent  = 0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default plane z = 1: every inside/outside mix, zero distance, extremes
    send_tri(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(tri_of(0, 0, 2*ONE, ONE, 0, 3*ONE, 0, ONE, 4*ONE, 24'hFFFFFF));
    send_tri(tri_of(0, 0, 2*ONE, ONE, 0, 0, 0, ONE, 0, 24'h123456));
    send_tri(tri_of(0, 0, 0, ONE, 0, 3*ONE, 0, ONE, 0, 24'hABCDEF));
    send_tri(tri_of(0, 0, 0, ONE, 0, 0, 0, ONE, 5*ONE, 24'h00FF00));
    send_tri(tri_of(0, 0, 2*ONE, ONE, 0, 3*ONE, 0, ONE, -ONE, 24'h0000FF));
    send_tri(tri_of(0, 0, 2*ONE, ONE, 0, -ONE, 0, ONE, 3*ONE, 24'hFF0000));
    send_tri(tri_of(0, 0, -ONE, ONE, 0, 2*ONE, 0, ONE, 3*ONE, 24'h800000));
    send_tri(tri_of(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE, 24'h000001));
    send_tri(tri_of(5, 6, ONE, 7, 8, ONE + 1, 9, 10, ONE, 24'h7FFFFF));
    send_tri(tri_of(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 24'hFFFFFF));
    send_tri(tri_of(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 0));
    send_tri(tri_of(0, 0, 32'h7FFFFFFF, -1, -1, 32'h80000000, 1, 1, 32'h80000000, 7));
    random_run(ITEMS_PER_PLANE - 13);

    // x plane through the origin, no gaps at all in this stretch
    set_plane(ONE, 0, 0, 0);
    no_gaps = 1'b1;
    send_tri(tri_of(-ONE, 0, 0, 0, 5, 0, ONE, 7, 9, 24'h55AA55));
    random_run(ITEMS_PER_PLANE);
    no_gaps = 1'b0;

    // largest magnitudes in every register
    set_plane(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    random_run(ITEMS_PER_PLANE);
    set_plane(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    random_run(ITEMS_PER_PLANE);

    // zero normal: all inside for positive w, none otherwise
    set_plane(0, 0, 0, ONE);
    random_run(20);
    set_plane(0, 0, 0, 0);
    random_run(20);

    // slanted unnormalized planes with random offsets
    repeat (4) begin
      set_plane(32'($urandom_range(2*ONE)) - ONE, 32'($urandom_range(2*ONE)) - ONE,
                32'($urandom_range(2*ONE)) - ONE, 32'($urandom_range(ONE)) - ONE/2);
      random_run(ITEMS_PER_PLANE / 2);
    end
    set_plane(0, 0, ONE, -ONE);
    random_run(ITEMS_PER_PLANE - 20);

    settle();
    $display("sent %0d triangles over several planes; checked %0d result triangles, %0d clipped",
             n_sent, n_results, n_clipped);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
